// ----- rtl/sbd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants of the box-filter downsampler
// Item formats, register indexes, sizing constants and the reciprocal table
// that turns the divide by the block area into a multiply.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // Sizing.
  localparam int MAX_OUT_WIDTH = 2048;
  localparam int MAX_FACTOR    = 8;
  localparam int COL_W         = $clog2(MAX_OUT_WIDTH);
  localparam int SUB_W         = $clog2(MAX_FACTOR);
  localparam int FACTOR_W      = 4;
  localparam int WIDTH_W       = 12;
  localparam int CHAN_W        = 8;
  localparam int SUM_W         = CHAN_W + 2 * SUB_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
  localparam logic [FACTOR_W-1:0]  FACTOR_RESET = FACTOR_W'(1);
  localparam logic [WIDTH_W-1:0]   WIDTH_RESET  = WIDTH_W'(640);

  // Queues.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);

  // Reciprocal multiply: floor(n / (f*f)) == (n * ceil(2^20 / (f*f))) >> 20
  // holds exactly for every n below 2^14 and f up to 8.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] avg0;
    logic [CHAN_W-1:0] avg1;
    logic [CHAN_W-1:0] avg2;
  } avg_t;

  typedef struct packed {
    logic [SUM_W-1:0] s0;
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] s2;
  } sums_t;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    pix_t             pix;
    logic [COL_W-1:0] col;
    logic             clear;  // first subpixel of a block row at this column
    logic             last;   // last subpixel of a block
    logic [SUB_W-1:0] fidx;   // effective factor minus one
  } job_t;

  // Head of the job queue as seen by the back end.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [SUB_W-1:0] fidx);
    logic [RECIP_W-1:0] r;
    unique case (fidx)
      3'd0: r = RECIP_W'(1048576);
      3'd1: r = RECIP_W'(262144);
      3'd2: r = RECIP_W'(116509);
      3'd3: r = RECIP_W'(65536);
      3'd4: r = RECIP_W'(41944);
      3'd5: r = RECIP_W'(29128);
      3'd6: r = RECIP_W'(21400);
      3'd7: r = RECIP_W'(16384);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/sbd_ram.sv -----
// ----------------------------------------------------------------------------
// sbd_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sbd_front.sv -----
// ----------------------------------------------------------------------------
// sbd_front: configuration registers and raster position tracking
// Accepts pixels, tags each with its column and block flags, and restarts
// the frame position on every write to the factor or width register.
// ----------------------------------------------------------------------------
module sbd_front import sbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  accept,
  input  pix_t                  pixel,
  output job_t                  job
);

  logic [FACTOR_W-1:0] factor;
  logic [WIDTH_W-1:0]  out_width;
  logic [SUB_W-1:0]    sub_col;
  logic [SUB_W-1:0]    sub_row;
  logic [COL_W-1:0]    out_col;

  logic [FACTOR_W-1:0] f_eff;
  logic [WIDTH_W-1:0]  w_eff;
  logic [COL_W-1:0]    col;
  logic [FACTOR_W-1:0] sub_col_p1;
  logic [FACTOR_W-1:0] sub_row_p1;
  logic [WIDTH_W-1:0]  col_p1;
  logic                block_done;

  always_comb begin
    if (factor == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = factor;
    end
    if (out_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (out_width > WIDTH_W'(MAX_OUT_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_OUT_WIDTH);
    end else begin
      w_eff = out_width;
    end
    col        = (WIDTH_W'(out_col) >= w_eff) ? '0 : out_col;
    sub_col_p1 = FACTOR_W'(sub_col) + FACTOR_W'(1);
    sub_row_p1 = FACTOR_W'(sub_row) + FACTOR_W'(1);
    col_p1     = WIDTH_W'(col) + WIDTH_W'(1);
    block_done = sub_col_p1 >= f_eff;

    job.pix   = pixel;
    job.col   = col;
    job.clear = (sub_row == '0) && (sub_col == '0);
    job.last  = block_done && (sub_row_p1 >= f_eff);
    job.fidx  = SUB_W'(f_eff - FACTOR_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factor    <= FACTOR_RESET;
      out_width <= WIDTH_RESET;
      sub_col   <= '0;
      sub_row   <= '0;
      out_col   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FACTOR: begin
          factor  <= wr_data[FACTOR_W-1:0];
          sub_col <= '0;
          sub_row <= '0;
          out_col <= '0;
        end
        REG_WIDTH: begin
          out_width <= wr_data[WIDTH_W-1:0];
          sub_col   <= '0;
          sub_row   <= '0;
          out_col   <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (block_done) begin
        sub_col <= '0;
        if (col_p1 >= w_eff) begin
          out_col <= '0;
          sub_row <= (sub_row_p1 >= f_eff) ? '0 : sub_row_p1[SUB_W-1:0];
        end else begin
          out_col <= col_p1[COL_W-1:0];
        end
      end else begin
        sub_col <= sub_col_p1[SUB_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/sbd_job_queue.sv -----
// ----------------------------------------------------------------------------
// sbd_job_queue: short queue of classified items
// Decouples the front end from the accumulate and divide pipeline.
// ----------------------------------------------------------------------------
module sbd_job_queue import sbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  job_t      wjob,
  input  logic      rd,
  output logic      full,
  output job_head_t head
);

  job_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QPTR_W:0]    count;

  assign full       = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wjob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/sbd_back.sv -----
// ----------------------------------------------------------------------------
// sbd_back: column-sum accumulation, block average and result queue
// Read-modify-write of the line store with forwarding, a reciprocal
// multiply for the divide, and a small queue of finished results.
// ----------------------------------------------------------------------------
module sbd_back import sbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_head_t head,
  output logic      take,
  output logic      empty,
  input  logic      pop,
  output avg_t      result
);

  // Accumulate stage.
  logic       b_valid;
  job_t       b_job;
  logic       b_fwd;
  sums_t      b_fwd_sum;
  sums_t      rd_sum;
  sums_t      base;
  sums_t      b_sum;

  // Divide stage.
  logic               c_valid;
  sums_t              c_sum;
  logic [RECIP_W-1:0] c_recip;
  logic [PROD_W-1:0]  prod0;
  logic [PROD_W-1:0]  prod1;
  logic [PROD_W-1:0]  prod2;
  avg_t               quot;

  // Result queue.
  avg_t               oslots [OUT_DEPTH];
  logic [OPTR_W-1:0]  owptr;
  logic [OPTR_W-1:0]  orptr;
  logic [OPTR_W:0]    ocount;
  logic [OPTR_W:0]    reserved;
  logic               opop;

  sbd_ram #(
    .WIDTH($bits(sums_t)),
    .DEPTH(MAX_OUT_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (b_valid),
    .waddr(b_job.col),
    .wdata(b_sum),
    .raddr(head.job.col),
    .rdata(rd_sum)
  );

  // Only take an item when every result already in flight has a slot.
  assign reserved = ocount + (OPTR_W + 1)'(b_valid && b_job.last) + (OPTR_W + 1)'(c_valid);
  assign take     = head.valid && (reserved < (OPTR_W + 1)'(OUT_DEPTH));

  always_comb begin
    if (b_job.clear) begin
      base = '0;
    end else if (b_fwd) begin
      base = b_fwd_sum;
    end else begin
      base = rd_sum;
    end
    b_sum.s0 = base.s0 + SUM_W'(b_job.pix.chan0);
    b_sum.s1 = base.s1 + SUM_W'(b_job.pix.chan1);
    b_sum.s2 = base.s2 + SUM_W'(b_job.pix.chan2);
  end

  always_ff @(posedge clk) begin
    b_job     <= head.job;
    // A write landing on the same edge as this read is not seen by the RAM.
    b_fwd     <= b_valid && (b_job.col == head.job.col);
    b_fwd_sum <= b_sum;
    c_sum     <= b_sum;
    c_recip   <= recip(b_job.fidx);
  end

  always_comb begin
    prod0     = PROD_W'(c_sum.s0) * PROD_W'(c_recip);
    prod1     = PROD_W'(c_sum.s1) * PROD_W'(c_recip);
    prod2     = PROD_W'(c_sum.s2) * PROD_W'(c_recip);
    quot.avg0 = prod0[RECIP_SHIFT +: CHAN_W];
    quot.avg1 = prod1[RECIP_SHIFT +: CHAN_W];
    quot.avg2 = prod2[RECIP_SHIFT +: CHAN_W];
  end

  assign empty  = ocount == '0;
  assign result = oslots[orptr];
  assign opop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (c_valid) begin
      oslots[owptr] <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      owptr   <= '0;
      orptr   <= '0;
      ocount  <= '0;
    end else begin
      b_valid <= take;
      c_valid <= b_valid && b_job.last;
      if (c_valid) begin
        owptr <= owptr + OPTR_W'(1);
      end
      if (opop) begin
        orptr <= orptr + OPTR_W'(1);
      end
      case ({c_valid, opop})
        2'b10:   ocount <= ocount + (OPTR_W + 1)'(1);
        2'b01:   ocount <= ocount - (OPTR_W + 1)'(1);
        default: ocount <= ocount;
      endcase
    end
  end

endmodule

// ----- rtl/supersample_box_downsample_unit.sv -----
// ----------------------------------------------------------------------------
// supersample_box_downsample_unit: box-filter image downsampler
// Averages each factor-by-factor block of a supersampled raster image into
// one output pixel, per channel, with truncating division.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one item per clock while full is low,
// through a queue-style port (push/full); averaged pixels leave through a
// second one (empty/pop). The sustained rate is one input item per cycle
// for every factor and width while results are popped; results come out
// one per completed block. With the job queue empty, the item completing
// a block passes the job queue and the accumulate and divide stages into
// the result queue, ready to be popped. The input rate is set by the line
// store, a single memory of MAX_OUT_WIDTH column sums with one write and one
// registered read port, which performs one read-modify-write per item; a
// forwarding register covers back-to-back items on the same column. The
// divide by the block area is a multiply by a tabled reciprocal, exact for
// every possible sum. Register writes (factor at index 0, out_width at index
// 1, any other index ignored) restart the frame position at the top-left
// corner and must be made while the block is idle. Out-of-range factor and
// width values are clamped into their legal ranges. The line store needs no
// clearing after reset: each column entry is cleared by the first subpixel
// of every block row that reaches it.
module supersample_box_downsample_unit import sbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes.
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  // Input pixels.
  input  logic                  push,
  output logic                  full,
  input  pix_t                  pixel,
  // Averaged pixels.
  output logic                  empty,
  input  logic                  pop,
  output avg_t                  result
);

  logic      accept;
  job_t      front_job;
  job_head_t head;
  logic      take;

  // An item is taken whenever the job queue has room.
  assign accept = push && !full;

  sbd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .accept  (accept),
    .pixel   (pixel),
    .job     (front_job)
  );

  // The queue lets the front keep accepting while the back waits for room
  // in its result queue.
  sbd_job_queue u_job_queue (
    .clk (clk),
    .rst (rst),
    .wr  (accept),
    .wjob(front_job),
    .rd  (take),
    .full(full),
    .head(head)
  );

  sbd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .take  (take),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

endmodule

// ----- rtl/sbd_checker.sv -----
// ----------------------------------------------------------------------------
// sbd_checker: port-level checks for the downsampler
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module sbd_checker import sbd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input avg_t result
);

  // Reset leaves both queues empty.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // No result can reach the output right after reset.
  assert property (@(posedge clk) rst |=> empty ##1 empty)
    else $error("result appeared too soon after reset");

  // A waiting result stays until it is taken.
  assert property (@(posedge clk) disable iff (rst) (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

  // A waiting result holds its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("waiting result changed");

endmodule

bind supersample_box_downsample_unit sbd_checker u_sbd_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .result(result)
);

// ----- tb/sbd_box_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbd_box_checker: scoreboard for the box-filter downsampler
// Follows register writes and accepted pixels, keeps its own line store of
// column sums, and compares every popped average with the oldest prediction.
// ----------------------------------------------------------------------------
module sbd_box_checker import sbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  push,
  input  logic                  full,
  input  pix_t                  pixel,
  input  logic                  empty,
  input  logic                  pop,
  input  avg_t                  result,
  output int                    mismatches,
  output int                    averages_due,
  output int                    pixels_in,
  output int                    averages_out
);

  logic [FACTOR_W-1:0] factor_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [SUB_W-1:0]    sub_col;
  logic [SUB_W-1:0]    sub_row;
  logic [COL_W-1:0]    out_col;
  sums_t               line_store [MAX_OUT_WIDTH];
  avg_t                expected_averages [$];
  int                  fail_tally;
  int                  pixel_tally;
  int                  average_tally;

  function automatic int block_edge(input logic [FACTOR_W-1:0] f);
    if (f == '0) return 1;
    if (int'(f) > MAX_FACTOR) return MAX_FACTOR;
    return int'(f);
  endfunction

  function automatic int row_columns(input logic [WIDTH_W-1:0] w);
    if (w == '0) return 1;
    if (int'(w) > MAX_OUT_WIDTH) return MAX_OUT_WIDTH;
    return int'(w);
  endfunction

  // One line per mismatch, and a running count.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%t checker: %s: got %0d, expected %0d", $time, what, got, want);
    fail_tally++;
  endtask

  // Adds one subpixel into its column sum and, on the last subpixel of a
  // block, queues the truncated average.
  task automatic accumulate_subpixel(input pix_t p);
    int    f;
    int    w;
    int    col;
    int    area;
    logic  last;
    sums_t s;
    avg_t  a;
    f   = block_edge(factor_reg);
    w   = row_columns(width_reg);
    col = int'(out_col);
    if (col >= w) col = 0;
    s = line_store[col];
    if (sub_row == '0 && sub_col == '0) s = '0;
    s.s0 = s.s0 + SUM_W'(p.chan0);
    s.s1 = s.s1 + SUM_W'(p.chan1);
    s.s2 = s.s2 + SUM_W'(p.chan2);
    line_store[col] = s;
    last = (int'(sub_row) + 1 >= f) && (int'(sub_col) + 1 >= f);
    if (last) begin
      area   = f * f;
      a.avg0 = CHAN_W'(int'(s.s0) / area);
      a.avg1 = CHAN_W'(int'(s.s1) / area);
      a.avg2 = CHAN_W'(int'(s.s2) / area);
      expected_averages.push_back(a);
    end
    if (int'(sub_col) + 1 >= f) begin
      sub_col = '0;
      col++;
      if (col >= w) begin
        col = 0;
        sub_row = (int'(sub_row) + 1 >= f) ? '0 : sub_row + 1'b1;
      end
    end else begin
      sub_col = sub_col + 1'b1;
    end
    out_col = COL_W'(col);
  endtask

  task automatic check_average(input avg_t got);
    avg_t want;
    if (expected_averages.size() == 0) begin
      report_mismatch("average with nothing predicted, avg0", int'(got.avg0), -1);
      return;
    end
    want = expected_averages.pop_front();
    if (got.avg0 !== want.avg0) report_mismatch("avg0", int'(got.avg0), int'(want.avg0));
    if (got.avg1 !== want.avg1) report_mismatch("avg1", int'(got.avg1), int'(want.avg1));
    if (got.avg2 !== want.avg2) report_mismatch("avg2", int'(got.avg2), int'(want.avg2));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      factor_reg = FACTOR_RESET;
      width_reg  = WIDTH_RESET;
      sub_col    = '0;
      sub_row    = '0;
      out_col    = '0;
      for (int i = 0; i < MAX_OUT_WIDTH; i++) line_store[i] = '0;
      expected_averages.delete();
      fail_tally    = 0;
      pixel_tally   = 0;
      average_tally = 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_FACTOR || wr_index == REG_WIDTH) begin
          if (wr_index == REG_FACTOR) factor_reg = wr_data[FACTOR_W-1:0];
          else width_reg = wr_data[WIDTH_W-1:0];
          sub_col = '0;
          sub_row = '0;
          out_col = '0;
        end
      end
      if (push && !full) begin
        accumulate_subpixel(pixel);
        pixel_tally++;
      end
      if (pop && !empty) begin
        check_average(result);
        average_tally++;
      end
    end
    mismatches   <= fail_tally;
    averages_due <= expected_averages.size();
    pixels_in    <= pixel_tally;
    averages_out <= average_tally;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the box-filter downsampler
// Streams supersampled pixels through a series of factor and width settings
// with random idling on both sides, and lets the checker judge every average.
// ----------------------------------------------------------------------------
module tb import sbd_pkg::*;;

  // Out-of-range register indexes; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  // The first average must still pass the pipeline after its last subpixel,
  // and a few pixels may still sit in the input queue; this margin covers both.
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int RANDOM_PIXELS  = 2000;
  localparam int MAX_IDLE       = 12;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = REG_FACTOR;
  logic [CFG_DATA_W-1:0] wr_data  = '0;
  logic                  push     = 1'b0;
  logic                  full;
  pix_t                  pixel    = '0;
  logic                  empty;
  logic                  pop      = 1'b0;
  avg_t                  result;

  int mismatches;
  int averages_due;
  int pixels_in;
  int averages_out;

  // Stimulus settings; hold_results is shared with the result sink.
  bit hold_results = 1'b0;
  int src_idle_max = 0;
  int settings_run = 0;

  // Register values as last written, used only to size the phases sensibly.
  logic [FACTOR_W-1:0] cur_factor = FACTOR_RESET;
  logic [WIDTH_W-1:0]  cur_width  = WIDTH_RESET;

  supersample_box_downsample_unit uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .full     (full),
    .pixel    (pixel),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

  sbd_box_checker chk (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .push         (push),
    .full         (full),
    .pixel        (pixel),
    .empty        (empty),
    .pop          (pop),
    .result       (result),
    .mismatches   (mismatches),
    .averages_due (averages_due),
    .pixels_in    (pixels_in),
    .averages_out (averages_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hard ceiling on the run. Even with every pixel and every average
  // waiting out the longest idle gap, the run is well under a tenth of this.
  initial begin
    #10000000;
    $display("Timed out with %0d averages still outstanding", averages_due);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Channel bytes lean towards the extremes now and then, so that saturated
  // sums and all-zero blocks turn up often.
  function automatic logic [CHAN_W-1:0] channel_byte();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.chan0 = channel_byte();
    p.chan1 = channel_byte();
    p.chan2 = channel_byte();
    return p;
  endfunction

  // Offers one pixel after a random idle gap and returns once it has been
  // taken. The push line is left high, so a following item with no gap goes
  // straight on; anything that waits must call hold_pixels first.
  task automatic send_pixel(input pix_t p);
    int gap;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic hold_pixels();
    push <= 1'b0;
  endtask

  // Waits until every predicted average has been popped, then a little
  // longer, since pixels that complete no block may still be in flight.
  task automatic drain_and_settle();
    hold_pixels();
    @(posedge clk);
    while (averages_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_FACTOR) cur_factor = data[FACTOR_W-1:0];
    if (idx == REG_WIDTH) cur_width = data[WIDTH_W-1:0];
    if (idx == REG_FACTOR || idx == REG_WIDTH) settings_run++;
  endtask

  // Result sink. It idles by its own draw, switching between busy and lazy
  // stretches, and once holds off completely when the stimulus asks, so that
  // both internal queues fill and the block has to stall its input.
  initial begin
    int gap;
    int sink_idle_max;
    int popped;
    sink_idle_max = 0;
    popped        = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (popped % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       sink_idle_max = 0;
          1:       sink_idle_max = 3;
          default: sink_idle_max = MAX_IDLE;
        endcase
      end
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        gap = $urandom_range(0, sink_idle_max);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      popped++;
    end
  end

  // Main stimulus: reset, a handful of directed items, a deliberate stall,
  // then random phases until enough pixels have gone in.
  initial begin
    int   n;
    int   pause_at;
    int   ef;
    int   ew;
    int   row_items;
    int   random_pixels;
    int   pick;
    logic first_phase;
    pix_t p;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings give factor 1, so each pixel is its own average:
    // all-zero, all-ones and a mixed pixel pass straight through.
    send_pixel('0);
    send_pixel('1);
    send_pixel('{chan0: 8'h12, chan1: 8'h34, chan2: 8'h56});

    // Factor 2 on a zero width, which the block takes as one column.
    drain_and_settle();
    write_reg(REG_FACTOR, CFG_DATA_W'(2));
    write_reg(REG_WIDTH, '0);
    repeat (4) send_pixel('1);

    // A write to a spare index in the middle of a block must not restart it.
    send_pixel('{chan0: 8'd0, chan1: 8'd1, chan2: 8'd2});
    send_pixel('{chan0: 8'd1, chan1: 8'd2, chan2: 8'd3});
    drain_and_settle();
    write_reg(REG_SPARE_LO, '1);
    send_pixel('{chan0: 8'd2, chan1: 8'd3, chan2: 8'd4});
    send_pixel('{chan0: 8'd3, chan1: 8'd4, chan2: 8'd0});

    // A real write part way through a block restarts the position, so the
    // three bright pixels before it must not leak into the next average.
    repeat (3) send_pixel('1);
    drain_and_settle();
    write_reg(REG_WIDTH, CFG_DATA_W'(1));
    repeat (3) send_pixel('{chan0: 8'd0, chan1: 8'd0, chan2: 8'd1});
    send_pixel('{chan0: 8'd7, chan1: 8'd255, chan2: 8'd2});

    // Factor zero with junk in the upper data bits, and the widest width
    // code, which saturates to the line store size.
    drain_and_settle();
    write_reg(REG_FACTOR, {8'hF0, 4'h0});
    write_reg(REG_WIDTH, '1);
    send_pixel('{chan0: 8'hA5, chan1: 8'h5A, chan2: 8'hFF});
    send_pixel('{chan0: 8'h5A, chan1: 8'hA5, chan2: 8'h00});

    // Back-pressure: the sink stops for a long stretch while pixels keep
    // coming at full rate, one average each.
    drain_and_settle();
    write_reg(REG_FACTOR, CFG_DATA_W'(1));
    write_reg(REG_WIDTH, CFG_DATA_W'(7));
    src_idle_max = 0;
    hold_results = 1'b1;
    repeat (48) send_pixel(random_pixel());

    // Random phases. Widths stay small most of the time so that whole block
    // rows complete; large widths appear too, and then only part of a row.
    random_pixels = 0;
    first_phase   = 1'b1;
    while (random_pixels < RANDOM_PIXELS) begin
      drain_and_settle();
      if (first_phase || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) write_reg(REG_FACTOR, {8'($urandom), 4'h0});
        else if (pick < 4)
          write_reg(REG_FACTOR, {8'($urandom), 4'($urandom_range(9, 15))});
        else if (pick < 12)
          write_reg(REG_FACTOR, {8'($urandom), 4'($urandom_range(1, 3))});
        else write_reg(REG_FACTOR, {8'($urandom), 4'($urandom_range(4, 8))});
      end
      if (first_phase || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) write_reg(REG_WIDTH, '0);
        else if (pick < 3) write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(2040, 4095)));
        else if (pick < 6) write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(5, 16)));
        else write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(1, 4)));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));

      ef = (cur_factor == '0) ? 1 : (int'(cur_factor) > MAX_FACTOR ? MAX_FACTOR : int'(cur_factor));
      ew = (cur_width == '0) ? 1 : (int'(cur_width) > MAX_OUT_WIDTH ? MAX_OUT_WIDTH : int'(cur_width));
      row_items = ew * ef * ef;
      if (row_items <= 512)
        n = row_items * $urandom_range(1, 2) + $urandom_range(0, row_items - 1);
      else
        n = $urandom_range(16, 160);
      // The last phase is cut short so that the total stays on target.
      if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;

      // Now and then the sender stops mid-phase until every average is out.
      pause_at = (first_phase || $urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
      src_idle_max = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 3 : MAX_IDLE);

      for (int k = 0; k < n; k++) begin
        if (k == pause_at) drain_and_settle();
        p = random_pixel();
        send_pixel(p);
      end
      random_pixels += n;
      first_phase = 1'b0;
    end

    drain_and_settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d pixels in, %0d averages out, %0d register settings applied,",
             pixels_in, averages_out, settings_run);
    $display("Summary: factors 0 to 15, widths 0 to 4095, one long sink hold-off.");
    if (mismatches == 0 && averages_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sbd_pkg.sv
rtl/sbd_ram.sv
rtl/sbd_front.sv
rtl/sbd_job_queue.sv
rtl/sbd_back.sv
rtl/supersample_box_downsample_unit.sv
rtl/sbd_checker.sv
tb/sbd_box_checker.sv
tb/tb.sv
